// File: src/laplacian_sharpen_filter_macros.svh
// ----------------------------------------------------------------------------
// laplacian_sharpen_filter_macros.svh
// Assertion macros for the Laplacian sharpening filter.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_FILTER_MACROS_SVH
`define LAPLACIAN_SHARPEN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define LSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: src/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants and types of the Laplacian sharpening filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int DIM_W     = 12;
	localparam int ROW_W     = 12;
	localparam int CMP_W     = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int PIX_W     = 8;
	localparam int LINE_W    = 2 * PIX_W;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);
	localparam logic [RQ_CW-1:0] RQ_FULL  = RQ_CW'(RQ_DEPTH);
	localparam logic [RQ_CW:0]   RQ_LIMIT = (RQ_CW + 1)'(RQ_DEPTH);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index (paddr bit above the word offset)
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] DIM_ONE      = DIM_W'(1);

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} frame_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] north;
		logic [PIX_W-1:0] south;
		logic [PIX_W-1:0] east;
		logic [PIX_W-1:0] west;
		logic [PIX_W-1:0] centre;
		logic             interior;
		logic             has_first;
		logic             last_row;
		logic             last_col;
	} kern_op_t;

	typedef struct packed {
		logic             has_first;
		logic [PIX_W-1:0] laplace;
		logic [PIX_W-1:0] sharp;
		logic             first_last;
		logic             has_second;
		logic             second_lof;
	} rec_t;

endpackage

// File: src/lsf_interfaces.sv
// ----------------------------------------------------------------------------
// lsf_interfaces
// Valid/ready channels of the filter: pixel words in, result words out.
// ----------------------------------------------------------------------------
interface lsf_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [lsf_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface lsf_result_if;
	logic                      valid;
	logic                      ready;
	logic [lsf_pkg::PIX_W-1:0] laplace_value;
	logic [lsf_pkg::PIX_W-1:0] sharpened_value;
	logic                      last_in_run;
	logic                      last_of_frame;

	modport source (output valid, output laplace_value, output sharpened_value,
		output last_in_run, output last_of_frame, input ready);
	modport sink   (input valid, input laplace_value, input sharpened_value,
		input last_in_run, input last_of_frame, output ready);
endinterface

// File: src/lsf_line_ram.sv
// ----------------------------------------------------------------------------
// lsf_line_ram
// Line store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lsf_line_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: src/lsf_apb_regs.sv
// ----------------------------------------------------------------------------
// lsf_apb_regs
// Frame size registers on an APB-style port; also keeps the clamped sizes.
// ----------------------------------------------------------------------------
module lsf_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lsf_pkg::APB_AW-1:0] paddr,
	input  logic [lsf_pkg::APB_DW-1:0] pwdata,
	output logic [lsf_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output lsf_pkg::frame_cfg_t        cfg
);

	logic [lsf_pkg::DIM_W-1:0] width_q;
	logic [lsf_pkg::DIM_W-1:0] height_q;
	lsf_pkg::frame_cfg_t       cfg_q;
	logic                      wr_en;
	logic                      reg_sel;
	logic [lsf_pkg::DIM_W-1:0] wr_val;
	logic [lsf_pkg::DIM_W-1:0] wr_width;
	logic [lsf_pkg::DIM_W-1:0] wr_height;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[lsf_pkg::APB_AW-1];
	assign wr_val  = pwdata[lsf_pkg::DIM_W-1:0];
	assign cfg     = cfg_q;

	always_comb begin
		if (wr_val == '0) begin
			wr_width = lsf_pkg::DIM_ONE;
		end else if (wr_val > lsf_pkg::WIDTH_MAX) begin
			wr_width = lsf_pkg::WIDTH_MAX;
		end else begin
			wr_width = wr_val;
		end
		wr_height = (wr_val == '0) ? lsf_pkg::DIM_ONE : wr_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= lsf_pkg::WIDTH_RESET;
			height_q     <= lsf_pkg::HEIGHT_RESET;
			cfg_q.width  <= lsf_pkg::WIDTH_RESET;
			cfg_q.height <= lsf_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				lsf_pkg::REG_FRAME_WIDTH: begin
					width_q     <= wr_val;
					cfg_q.width <= wr_width;
				end
				lsf_pkg::REG_FRAME_HEIGHT: begin
					height_q     <= wr_val;
					cfg_q.height <= wr_height;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			lsf_pkg::REG_FRAME_WIDTH:  prdata = lsf_pkg::APB_DW'(width_q);
			lsf_pkg::REG_FRAME_HEIGHT: prdata = lsf_pkg::APB_DW'(height_q);
			default:                   prdata = '0;
		endcase
	end

endmodule

// File: src/lsf_kernel.sv
// ----------------------------------------------------------------------------
// lsf_kernel
// Stage 1: 4-neighbour Laplacian and sharpening with clipping; builds the
// result record of one pixel.
// ----------------------------------------------------------------------------
module lsf_kernel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  lsf_pkg::kern_op_t op,
	output logic              rec_push,
	output lsf_pkg::rec_t     rec
);

	lsf_pkg::kern_op_t  op_s1;
	logic               valid_s1;
	logic [9:0]         sum;
	logic [9:0]         c4;
	logic [10:0]        c5;
	logic signed [11:0] lap_raw;
	logic signed [11:0] sharp_raw;

	function automatic logic [7:0] clip8(input logic signed [11:0] v);
		logic [7:0] r;
		if (v < 12'sd0) begin
			r = 8'd0;
		end else if (v > 12'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid) begin
			op_s1 <= op;
		end
	end

	always_comb begin
		sum = 10'(op_s1.north) + 10'(op_s1.south) + 10'(op_s1.east) + 10'(op_s1.west);
		c4  = {op_s1.centre, 2'b00};
		c5  = 11'(c4) + 11'(op_s1.centre);
		lap_raw   = $signed({2'b00, sum}) - $signed({2'b00, c4});
		sharp_raw = $signed({1'b0, c5}) - $signed({2'b00, sum});

		rec.has_first  = op_s1.has_first;
		rec.laplace    = op_s1.interior ? clip8(lap_raw) : 8'd0;
		rec.sharp      = op_s1.interior ? clip8(sharp_raw) : 8'd0;
		rec.first_last = ~op_s1.last_row;
		rec.has_second = op_s1.last_row;
		rec.second_lof = op_s1.last_col;
	end

	assign rec_push = valid_s1 & (op_s1.has_first | op_s1.last_row);

endmodule

// File: src/lsf_result_queue.sv
// ----------------------------------------------------------------------------
// lsf_result_queue
// Queue of per-pixel result records; unpacks each into one or two words.
// ----------------------------------------------------------------------------
module lsf_result_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  lsf_pkg::rec_t             din,
	output logic [lsf_pkg::RQ_CW-1:0] count,
	lsf_result_if.source              results
);

	lsf_pkg::rec_t             mem_q [lsf_pkg::RQ_DEPTH];
	logic [lsf_pkg::RQ_AW-1:0] wptr_q;
	logic [lsf_pkg::RQ_AW-1:0] rptr_q;
	logic [lsf_pkg::RQ_CW-1:0] count_q;
	logic                      phase_q;
	lsf_pkg::rec_t             head;
	logic                      out_valid;
	logic                      out_acc;
	logic                      cur_first;
	logic                      last_word;
	logic                      pop;

	assign head      = mem_q[rptr_q];
	assign out_valid = (count_q != '0);
	assign out_acc   = out_valid & results.ready;
	assign cur_first = head.has_first & ~phase_q;
	assign last_word = ~(cur_first & head.has_second);
	assign pop       = out_acc & last_word;
	assign count     = count_q;

	assign results.valid           = out_valid;
	assign results.laplace_value   = cur_first ? head.laplace : '0;
	assign results.sharpened_value = cur_first ? head.sharp : '0;
	assign results.last_in_run     = cur_first ? head.first_last : 1'b1;
	assign results.last_of_frame   = cur_first ? 1'b0 : head.second_lof;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + lsf_pkg::RQ_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + lsf_pkg::RQ_AW'(1);
			end
			count_q <= count_q + lsf_pkg::RQ_CW'(push) - lsf_pkg::RQ_CW'(pop);
			if (out_acc) begin
				phase_q <= ~last_word;
			end
		end
	end

endmodule

// File: src/laplacian_sharpen_filter.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_filter
// 3x3 four-neighbour Laplacian and sharpening over a raster pixel stream.
//
//   channel   dir  handshake      word
//   pixels    in   valid/ready    pixel
//   results   out  valid/ready    laplace_value, sharpened_value,
//                                 last_in_run, last_of_frame
//   apb       in   psel/penable   frame_width @0x0, frame_height @0x4
//
// One pixel per clock while ready is high; a pixel of the last row gives two
// words, so there the single result channel holds input back.
// A word's path from its pixel: line-store window, kernel stage, result
// queue. The line store is read one and two columns ahead at each accept.
// Reset clears position, kernel and queue; line stores are not cleared.
// ready drops when the 4-entry result queue could overflow.
// ----------------------------------------------------------------------------
`include "laplacian_sharpen_filter_macros.svh"

module laplacian_sharpen_filter (
	input  logic                       clk,
	input  logic                       arst_n,
	lsf_pixel_if.sink                  pixels,
	lsf_result_if.source               results,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lsf_pkg::APB_AW-1:0] paddr,
	input  logic [lsf_pkg::APB_DW-1:0] pwdata,
	output logic [lsf_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	lsf_pkg::frame_cfg_t        cfg;
	logic [lsf_pkg::COL_W-1:0]  col_q;
	logic [lsf_pkg::ROW_W-1:0]  row_q;
	logic [lsf_pkg::PIX_W-1:0]  west_q;
	logic                       fwd_a_q;
	logic                       fwd_b_q;
	logic [lsf_pkg::LINE_W-1:0] fwd_data_q;
	logic [lsf_pkg::LINE_W-1:0] rd_a;
	logic [lsf_pkg::LINE_W-1:0] rd_b;
	logic [lsf_pkg::LINE_W-1:0] cur_line;
	logic [lsf_pkg::LINE_W-1:0] nxt_line;
	logic [lsf_pkg::LINE_W-1:0] wr_line;
	logic [lsf_pkg::COL_W-1:0]  col_next;
	logic [lsf_pkg::COL_W-1:0]  col_ahead;
	logic                       pix_acc;
	logic                       last_col;
	logic                       last_row;
	logic                       has_first;
	logic                       col_border;
	logic                       interior;
	lsf_pkg::kern_op_t          op;
	logic                       rec_push;
	lsf_pkg::rec_t              rec;
	logic [lsf_pkg::RQ_CW-1:0]  rq_count;

	lsf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// entry: [15:8] two rows up, [7:0] one row up
	lsf_line_ram #(
		.DEPTH (lsf_pkg::MAX_WIDTH),
		.WIDTH (lsf_pkg::LINE_W)
	) u_lines (
		.clk     (clk),
		.we      (pix_acc),
		.waddr   (col_q),
		.wdata   (wr_line),
		.re      (pix_acc),
		.raddr_a (col_next),
		.raddr_b (col_ahead),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign pix_acc = pixels.valid & pixels.ready;
	assign pixels.ready = ({1'b0, rq_count} + {{lsf_pkg::RQ_CW{1'b0}}, rec_push})
		< lsf_pkg::RQ_LIMIT;

	// same-edge write bypass (narrow frames)
	assign cur_line = fwd_a_q ? fwd_data_q : rd_a;
	assign nxt_line = fwd_b_q ? fwd_data_q : rd_b;
	assign wr_line  = {cur_line[lsf_pkg::PIX_W-1:0], pixels.pixel};

	always_comb begin
		last_col   = (lsf_pkg::CMP_W'(col_q) + lsf_pkg::CMP_W'(1))
			>= lsf_pkg::CMP_W'(cfg.width);
		last_row   = ({1'b0, row_q} + (lsf_pkg::ROW_W + 1)'(1)) >= {1'b0, cfg.height};
		has_first  = (row_q != '0);
		col_border = (col_q == '0) | last_col;
		interior   = has_first & (row_q != lsf_pkg::ROW_W'(1)) & (row_q < cfg.height)
			& ~col_border & (col_q != lsf_pkg::COL_LAST);
		col_next   = last_col ? '0 : col_q + lsf_pkg::COL_W'(1);
		col_ahead  = col_next + lsf_pkg::COL_W'(1);

		op.north     = cur_line[lsf_pkg::LINE_W-1:lsf_pkg::PIX_W];
		op.centre    = cur_line[lsf_pkg::PIX_W-1:0];
		op.east      = nxt_line[lsf_pkg::PIX_W-1:0];
		op.west      = west_q;
		op.south     = pixels.pixel;
		op.interior  = interior;
		op.has_first = has_first;
		op.last_row  = last_row;
		op.last_col  = last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
		end else if (pix_acc) begin
			col_q   <= col_next;
			fwd_a_q <= (col_next == col_q);
			fwd_b_q <= (col_ahead == col_q);
			if (last_col) begin
				row_q <= last_row ? '0 : row_q + lsf_pkg::ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			fwd_data_q <= wr_line;
			west_q     <= cur_line[lsf_pkg::PIX_W-1:0];
		end
	end

	lsf_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (pix_acc),
		.op       (op),
		.rec_push (rec_push),
		.rec      (rec)
	);

	lsf_result_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.din     (rec),
		.count   (rq_count),
		.results (results)
	);

	`LSF_ASSERT_IMPL(a_queue_room, clk, arst_n, rec_push, rq_count < lsf_pkg::RQ_FULL, "result queue overflow")
	`LSF_ASSERT_NEXT(a_first_row_quiet, clk, arst_n, pix_acc && !has_first && !last_row, !rec_push, "first-row pixel produced a result")
	`LSF_ASSERT_NEXT(a_last_row_pair, clk, arst_n, pix_acc && last_row, rec_push && rec.has_second, "last-row pixel lost its border word")

endmodule
